// ----- rtl/head_angle_to_servo_pulse_assert.svh -----
// Assertion macros for the head angle to servo pulse block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef HEAD_ANGLE_TO_SERVO_PULSE_ASSERT_SVH
`define HEAD_ANGLE_TO_SERVO_PULSE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define HATSP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define HATSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hatsp_pkg.sv -----
// Constants and types for the head angle to servo pulse block.
// No dependencies.
package hatsp_pkg;

	localparam int FILTER_FRAC_BITS = 8;
	localparam int PULSE_BITS       = 12;

	localparam int AXES  = 3;
	localparam int ANG_W = 14;
	localparam int OFF_W = ANG_W + 1;
	localparam int FILT_W = OFF_W + FILTER_FRAC_BITS + 1;

	// filter weights are in 1/256 units
	localparam int BETA_W     = 9;
	localparam int BETA_SHIFT = 8;
	localparam int BETA_ONE   = 1 << BETA_SHIFT;
	localparam int GAIN_W     = 12;

	// shared multiplier
	localparam int MA_W   = FILT_W + 1;
	localparam int MB_W   = GAIN_W + 1;
	localparam int PROD_W = MA_W + MB_W;
	localparam int PULSE_SHIFT = BETA_SHIFT + FILTER_FRAC_BITS;
	localparam int P_W    = PROD_W - PULSE_SHIFT + 2;

	// angles in 1/16 degree
	localparam int WRAP_SPAN  = 5760;
	localparam int WRAP_HALF  = 2880;
	localparam int WRAP_W     = OFF_W + 1;
	localparam int NINETY_DEG = 1440;
	localparam int FILT_RESET = NINETY_DEG << FILTER_FRAC_BITS;

	localparam int IN_TDATA_W  = ((AXES * ANG_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((AXES * PULSE_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TR_BETA,
		REG_PAN_BETA,
		REG_GAIN,
		REG_REVERSE,
		REG_CENTER,
		REG_PMIN,
		REG_PMAX
	} cfg_reg_t;

	localparam logic [BETA_W-1:0]     RST_TR_BETA  = BETA_W'(192);
	localparam logic [BETA_W-1:0]     RST_PAN_BETA = BETA_W'(192);
	localparam logic [GAIN_W-1:0]     RST_GAIN     = GAIN_W'(272);
	localparam logic [AXES-1:0]       RST_REVERSE  = AXES'(7);
	localparam logic [PULSE_BITS-1:0] RST_CENTER   = PULSE_BITS'(2200);
	localparam logic [PULSE_BITS-1:0] RST_PMIN     = PULSE_BITS'(1200);
	localparam logic [PULSE_BITS-1:0] RST_PMAX     = PULSE_BITS'(3200);

	// weights above one are taken as one
	function automatic logic [BETA_W-1:0] beta_clip(input logic [BETA_W-1:0] b);
		return b[BETA_W-1] ? BETA_W'(BETA_ONE) : b;
	endfunction

endpackage

// ----- rtl/head_angle_to_servo_pulse.sv -----
// Top level of the head angle to servo pulse block: sequencer, filter state,
// shared multiplier and output register. Uses hatsp_pkg and the assert macros.
`include "head_angle_to_servo_pulse_assert.svh"

// Takes one pan/tilt/roll sample (1/16 degree) per item and, once tracking,
// returns three clamped servo pulses. The first sample after reset, or one with
// recenter set, becomes the centre; no result is given until a recenter has been
// seen. From accept to result an item passes through these steps: form offsets,
// wrap the pan offset, then per axis the new-sample term, old-value term and gain
// on the single shared multiplier followed by round/clamp, and last load the
// output register, held off for as long as an earlier result is still unread.
// s_tready is low while an item is being worked on and rises the cycle after the
// result is loaded; a sample taken before tracking starts gives no result and
// frees the input as soon as its centre capture step is done. A finished result
// waits in the output register while the next item is taken.
module head_angle_to_servo_pulse (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [hatsp_pkg::IN_TDATA_W-1:0]        s_tdata,  // pan_in, tilt_in, roll_in
	input  logic [0:0]                              s_tuser,  // recenter
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [hatsp_pkg::OUT_TDATA_W-1:0]       m_tdata,  // pan, tilt, roll pulse
	input  logic                                    cfg_we,
	input  logic [hatsp_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [hatsp_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import hatsp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CAP, S_WRAP, S_FA, S_FB, S_PM, S_PF, S_OUT
	} state_t;

	localparam logic [1:0] AX_LAST = 2'(AXES - 1);

	// configuration
	logic [BETA_W-1:0]     tr_beta_q, pan_beta_q;
	logic [GAIN_W-1:0]     gain_q;
	logic [AXES-1:0]       reverse_q;
	logic [PULSE_BITS-1:0] center_pulse_q, pulse_min_q, pulse_max_q;

	state_t                      state_q;
	logic [1:0]                  ax_q;
	logic                        pending_q, tracking_q, rec_q;
	logic signed [ANG_W-1:0]     ang_q  [AXES];
	logic signed [ANG_W-1:0]     cen_q  [AXES];
	logic signed [OFF_W-1:0]     off_q  [AXES];
	logic signed [FILT_W-1:0]    filt_q [AXES];
	logic [PULSE_BITS-1:0]       pulse_q[AXES];
	logic signed [WRAP_W-1:0]    wrap_q;
	logic signed [PROD_W-1:0]    acc_q, prod_q;
	logic                        m_tvalid_q;
	logic [OUT_TDATA_W-1:0]      m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_beta_q      <= RST_TR_BETA;
			pan_beta_q     <= RST_PAN_BETA;
			gain_q         <= RST_GAIN;
			reverse_q      <= RST_REVERSE;
			center_pulse_q <= RST_CENTER;
			pulse_min_q    <= RST_PMIN;
			pulse_max_q    <= RST_PMAX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TR_BETA:  tr_beta_q      <= cfg_data[BETA_W-1:0];
				REG_PAN_BETA: pan_beta_q     <= cfg_data[BETA_W-1:0];
				REG_GAIN:     gain_q         <= cfg_data[GAIN_W-1:0];
				REG_REVERSE:  reverse_q      <= cfg_data[AXES-1:0];
				REG_CENTER:   center_pulse_q <= cfg_data[PULSE_BITS-1:0];
				REG_PMIN:     pulse_min_q    <= cfg_data[PULSE_BITS-1:0];
				REG_PMAX:     pulse_max_q    <= cfg_data[PULSE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// centre capture and offsets
	logic                     cap;
	logic signed [ANG_W-1:0]  cen_new [AXES];
	logic signed [OFF_W-1:0]  off_new [AXES];
	logic signed [WRAP_W-1:0] wrap_new;

	always_comb begin
		cap = rec_q | pending_q;
		for (int i = 0; i < AXES; i++) begin
			cen_new[i] = cap ? ang_q[i] : cen_q[i];
			off_new[i] = OFF_W'(ang_q[i]) - OFF_W'(cen_new[i]);
		end
		wrap_new = WRAP_W'(off_new[0]) + WRAP_W'(WRAP_HALF);
	end

	// shared multiplier
	logic [BETA_W-1:0]         beta_eff;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	always_comb begin
		beta_eff = beta_clip((ax_q == 2'd0) ? pan_beta_q : tr_beta_q);
		mul_a = MA_W'(filt_q[ax_q]);
		mul_b = $signed(MB_W'(gain_q));
		unique case (state_q)
			S_FA: begin
				mul_a = MA_W'(off_q[ax_q]);
				mul_b = $signed(MB_W'(beta_eff));
			end
			S_FB: begin
				mul_b = $signed(MB_W'(BETA_W'(BETA_ONE) - beta_eff));
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// filter update: floor((acc + old term) / 256), rounding folded into acc
	logic signed [PROD_W-1:0] fb_sum;
	logic signed [FILT_W-1:0] filt_new;

	always_comb begin
		fb_sum   = acc_q + mul_p;
		filt_new = FILT_W'(fb_sum >>> BETA_SHIFT);
	end

	// pulse: truncate toward zero, sign, offset, clamp (lower limit first)
	logic signed [PROD_W-1:0]  tq;
	logic signed [P_W-1:0]     sc, sn, pv, pc, lo, hi;

	always_comb begin
		tq = prod_q + (prod_q[PROD_W-1] ? PROD_W'((1 << PULSE_SHIFT) - 1) : PROD_W'(0));
		sc = P_W'(tq >>> PULSE_SHIFT);
		sn = reverse_q[ax_q] ? -sc : sc;
		pv = sn + $signed(P_W'(center_pulse_q));
		lo = $signed(P_W'(pulse_min_q));
		hi = $signed(P_W'(pulse_max_q));
		pc = pv;
		if (pv < lo)
			pc = lo;
		if (pc > hi)
			pc = hi;
	end

	// output register loads once the previous result has left
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ax_q       <= '0;
			pending_q  <= 1'b1;
			tracking_q <= 1'b0;
			rec_q      <= 1'b0;
			wrap_q     <= '0;
			acc_q      <= '0;
			prod_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			for (int i = 0; i < AXES; i++) begin
				ang_q[i]   <= '0;
				cen_q[i]   <= '0;
				off_q[i]   <= '0;
				filt_q[i]  <= FILT_W'(FILT_RESET);
				pulse_q[i] <= '0;
			end
		end else begin
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						for (int i = 0; i < AXES; i++)
							ang_q[i] <= s_tdata[i*ANG_W +: ANG_W];
						rec_q   <= s_tuser[0];
						state_q <= S_CAP;
					end
				end
				S_CAP: begin
					for (int i = 0; i < AXES; i++) begin
						cen_q[i] <= cen_new[i];
						off_q[i] <= off_new[i];
					end
					pending_q <= 1'b0;
					wrap_q    <= wrap_new;
					if (tracking_q || rec_q) begin
						tracking_q <= 1'b1;
						state_q    <= S_WRAP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WRAP: begin
					// floor modulo by repeated add/subtract of one span
					if (wrap_q[WRAP_W-1]) begin
						wrap_q <= wrap_q + WRAP_W'(WRAP_SPAN);
					end else if (wrap_q >= $signed(WRAP_W'(WRAP_SPAN))) begin
						wrap_q <= wrap_q - WRAP_W'(WRAP_SPAN);
					end else begin
						off_q[0] <= OFF_W'(wrap_q - WRAP_W'(WRAP_HALF));
						ax_q     <= '0;
						state_q  <= S_FA;
					end
				end
				S_FA: begin
					acc_q   <= (mul_p <<< FILTER_FRAC_BITS) + PROD_W'(1 << (BETA_SHIFT - 1));
					state_q <= S_FB;
				end
				S_FB: begin
					filt_q[ax_q] <= filt_new;
					state_q      <= S_PM;
				end
				S_PM: begin
					prod_q  <= mul_p;
					state_q <= S_PF;
				end
				S_PF: begin
					pulse_q[ax_q] <= PULSE_BITS'(pc);
					if (ax_q == AX_LAST) begin
						state_q <= S_OUT;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_FA;
					end
				end
				S_OUT: begin
					if (out_load) begin
						m_tdata_q  <= OUT_TDATA_W'({pulse_q[2], pulse_q[1], pulse_q[0]});
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`HATSP_ASSERT_SAME(a_no_result_untracked, m_tvalid_q, tracking_q,
		"result shown before tracking started")
	`HATSP_ASSERT_NEXT(a_recenter_tracks, (state_q == S_CAP) && rec_q,
		tracking_q && !pending_q && (state_q == S_WRAP), "recenter did not start tracking")
	`HATSP_ASSERT_SAME(a_pan_wrapped, (state_q == S_FA) && (ax_q == 2'd0),
		(off_q[0] >= -WRAP_HALF) && (off_q[0] < WRAP_HALF), "pan offset not wrapped")
	`HATSP_ASSERT_SAME(a_pulse_limits, m_tvalid_q && (pulse_min_q <= pulse_max_q),
		(m_tdata_q[PULSE_BITS-1:0] >= pulse_min_q) && (m_tdata_q[PULSE_BITS-1:0] <= pulse_max_q)
		&& (m_tdata_q[2*PULSE_BITS-1:PULSE_BITS] >= pulse_min_q)
		&& (m_tdata_q[2*PULSE_BITS-1:PULSE_BITS] <= pulse_max_q),
		"pulse outside limits")

endmodule
